[sv/bcc_pkg.sv]
// ============================================================================
// bcc_pkg: shared definitions for the button click classifier
// Gesture codes, register indexes, threshold reset values and default widths.
// ============================================================================
package bcc_pkg;

    // Default width of the tick counters.
    localparam int COUNT_WIDTH_DEF = 32;

    // Width of a threshold register and of the configuration data bus.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_GAP  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS  = 2'd2;

    // Threshold values after reset.
    localparam logic [CFG_DATA_W-1:0] DOUBLE_GAP_RST  = 32'd300;
    localparam logic [CFG_DATA_W-1:0] SHORT_PRESS_RST = 32'd500;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST  = 32'd1000;

    // Gesture codes carried by a result.
    typedef enum logic [1:0] {
        GESTURE_NONE   = 2'd0,
        GESTURE_SINGLE = 2'd1,
        GESTURE_DOUBLE = 2'd2,
        GESTURE_LONG   = 2'd3
    } gesture_t;

endpackage

[sv/button_click_classifier.sv]
// ============================================================================
// button_click_classifier: single, double and long press detector
// Classifies samples of one active-low button into click gestures.
// ============================================================================
// Usage:
// Each request on the s_ channel carries one sample of the button line
// (1 released, 0 pressed), taken at one time tick. Every request yields
// exactly one result on the m_ channel: the gesture code, which is none for
// most samples. The three thresholds are written through the cfg_ port at
// any time the block is idle; index 3 is ignored.
// A sample is held in the input register, then classified, with the counters
// updated, as it moves into the output register. Throughput is one sample per
// cycle while the receiver takes results; the counter update and the threshold
// compares are combinational.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more sample, after which s_ready drops.
// A synchronous reset (aresetn low) empties both registers, clears the
// counters and pending flags, marks the line as released and loads the
// default thresholds.
// ============================================================================
module button_click_classifier #(
    parameter int COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Sample channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_button_level,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_gesture,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [bcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bcc_pkg::*;

    // Compare width covers both the counters and the thresholds.
    localparam int CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [CFG_DATA_W-1:0]  double_gap_reg;
    logic [CFG_DATA_W-1:0]  short_press_reg;
    logic [CFG_DATA_W-1:0]  long_press_reg;

    logic                   in_valid_reg;
    logic                   in_level_reg;
    logic                   out_valid_reg;
    gesture_t               out_gesture_reg;
    gesture_t               gesture_next;

    logic                   prev_level_reg, prev_level_next;
    logic [COUNT_WIDTH-1:0] since_press_reg, since_press_next;
    logic [COUNT_WIDTH-1:0] since_release_reg, since_release_next;
    logic [COUNT_WIDTH-1:0] held_reg, held_next;
    logic                   pending_reg, pending_next;
    logic                   long_done_reg, long_done_next;

    logic                   out_free;
    logic                   advance;
    logic                   press_edge;
    logic                   release_edge;

    // Handshake: the output register frees when empty or taken, and the input
    // register frees when it moves into the output register.
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = out_valid_reg;
    assign m_gesture = out_gesture_reg;

    // Threshold registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            double_gap_reg  <= DOUBLE_GAP_RST;
            short_press_reg <= SHORT_PRESS_RST;
            long_press_reg  <= LONG_PRESS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DOUBLE_GAP:  double_gap_reg  <= cfg_wdata;
                REG_SHORT_PRESS: short_press_reg <= cfg_wdata;
                REG_LONG_PRESS:  long_press_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Classification of the sample held in the input register.
    always_comb begin
        since_press_next   = (since_press_reg == CNT_MAX) ? since_press_reg
                                                          : since_press_reg + 1'b1;
        since_release_next = (since_release_reg == CNT_MAX) ? since_release_reg
                                                            : since_release_reg + 1'b1;
        held_next       = held_reg;
        pending_next    = pending_reg;
        long_done_next  = long_done_reg;
        prev_level_next = in_level_reg;
        gesture_next    = GESTURE_NONE;

        press_edge   = !in_level_reg && prev_level_reg;
        release_edge = in_level_reg && !prev_level_reg;

        // A press restarts the press counter and rearms the long press.
        if (press_edge) begin
            since_press_next = '0;
            long_done_next   = 1'b0;
        end

        // A release captures the press length and completes or opens a click.
        if (release_edge) begin
            since_release_next = '0;
            held_next          = since_press_next;
            if (pending_reg) begin
                gesture_next = GESTURE_DOUBLE;
                pending_next = 1'b0;
            end else begin
                pending_next   = 1'b1;
                long_done_next = 1'b0;
            end
        end

        // Timeouts: the gap after a release, or a press held long enough.
        if (in_level_reg && pending_next
                && (CMP_W'(since_release_next) > CMP_W'(double_gap_reg))) begin
            if (CMP_W'(held_next) < CMP_W'(short_press_reg)) begin
                gesture_next = GESTURE_SINGLE;
            end
            pending_next = 1'b0;
        end else if (!in_level_reg && !long_done_next
                && (CMP_W'(since_press_next) > CMP_W'(long_press_reg))) begin
            gesture_next   = GESTURE_LONG;
            long_done_next = 1'b1;
            pending_next   = 1'b0;
        end
    end

    // Input register, output register and gesture state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            prev_level_reg    <= 1'b1;
            since_press_reg   <= '0;
            since_release_reg <= '0;
            held_reg          <= '0;
            pending_reg       <= 1'b0;
            long_done_reg     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_level_reg <= s_button_level;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg     <= 1'b1;
                out_gesture_reg   <= gesture_next;
                prev_level_reg    <= prev_level_next;
                since_press_reg   <= since_press_next;
                since_release_reg <= since_release_next;
                held_reg          <= held_next;
                pending_reg       <= pending_next;
                long_done_reg     <= long_done_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench for the button click classifier
// Streams button samples through the valid/ready channels while a scoreboard
// predicts the gesture of every sample. Short directed sequences run first,
// the last one driving the counters into saturation, followed by threshold
// phases with well-formed random press/release sequences, glitch noise and
// randomized sender gaps and receiver stalls.
// ============================================================================
module tb;
    import bcc_pkg::*;

    // Narrow counters so that saturation is reached within the run.
    localparam int CNT_W = 8;
    localparam int QUIET_LIMIT = 1000;
    // The unused register slot; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_mode_t;
    typedef enum logic [1:0] {THR_SMALL, THR_ZERO, THR_MAX, THR_MIXED} thr_kind_t;

    // ------------------------------------------------------------------------
    // Gesture predictor and store of expected gestures.
    // ------------------------------------------------------------------------
    class gesture_scoreboard;
        logic [CFG_DATA_W-1:0] gap_thr;
        logic [CFG_DATA_W-1:0] click_thr;
        logic [CFG_DATA_W-1:0] hold_thr;
        logic                  last_level;
        logic [CNT_W-1:0]      since_press;
        logic [CNT_W-1:0]      since_release;
        logic [CNT_W-1:0]      held_len;
        bit                    click_waiting;
        bit                    long_done;
        gesture_t              expected_q[$];
        int unsigned           errors;

        function new();
            gap_thr       = DOUBLE_GAP_RST;
            click_thr     = SHORT_PRESS_RST;
            hold_thr      = LONG_PRESS_RST;
            last_level    = 1'b1;
            since_press   = '0;
            since_release = '0;
            held_len      = '0;
            click_waiting = 1'b0;
            long_done     = 1'b0;
            errors        = 0;
        endfunction

        function void set_threshold(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DOUBLE_GAP:  gap_thr = val;
                REG_SHORT_PRESS: click_thr = val;
                REG_LONG_PRESS:  hold_thr = val;
                default: ;
            endcase
        endfunction

        function int unsigned backlog();
            return expected_q.size();
        endfunction

        // Classify one accepted sample and queue the gesture it must produce.
        function void note_sample(logic lvl);
            gesture_t g;
            g = GESTURE_NONE;
            if (since_press != '1) since_press++;
            if (since_release != '1) since_release++;

            // Press edge restarts the press timer.
            if (!lvl && last_level) begin
                since_press = '0;
                long_done = 1'b0;
            end

            // Release edge latches the press length and pairs clicks.
            if (lvl && !last_level) begin
                since_release = '0;
                held_len = since_press;
                if (click_waiting) begin
                    g = GESTURE_DOUBLE;
                    click_waiting = 1'b0;
                end else begin
                    click_waiting = 1'b1;
                    long_done = 1'b0;
                end
            end

            // Timeouts: gap after a release, or a press held too long.
            if (lvl && click_waiting && since_release > gap_thr) begin
                if (held_len < click_thr) g = GESTURE_SINGLE;
                click_waiting = 1'b0;
            end else if (!lvl && !long_done && since_press > hold_thr) begin
                g = GESTURE_LONG;
                long_done = 1'b1;
                click_waiting = 1'b0;
            end

            last_level = lvl;
            expected_q.push_back(g);
        endfunction

        function void check_gesture(logic [1:0] got);
            gesture_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: gesture %0d arrived with none expected", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                $display("%0t: gesture mismatch: expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test.
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_button_level = 1'b1;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_gesture;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    gesture_scoreboard sb;
    int unsigned       samples_sent = 0;
    int unsigned       burst_left = 0;
    bit                gaps_on = 1'b1;
    int unsigned       quiet_cycles = 0;
    rx_mode_t          rx_mode = RX_ALWAYS;
    logic [7:0]        rx_left = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    button_click_classifier #(.COUNT_WIDTH(CNT_W)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gesture      (m_gesture),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // Monitor: every accepted request feeds the predictor, every result is checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_sample(s_button_level);
            if (m_valid && m_ready) sb.check_gesture(m_gesture);
        end
    end

    // Receiver stalls: the pattern is redrawn whenever its countdown runs out.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= 8'($urandom_range(32, 200));
        end else begin
            rx_left <= rx_left - 1'b1;
        end
        case (rx_mode)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_ready <= (rx_left[2:0] == 3'd0);
            default:   m_ready <= (rx_left[4:2] != 3'd0);
        endcase
    end

    // Watchdog: ends the run when no request moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------
    task automatic idle_sender(input int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Send one sample; when gaps are on, gaps fall between bursts of random length.
    task automatic put_level(input logic lvl);
        if (burst_left == 0) begin
            if (gaps_on) idle_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_button_level <= lvl;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    task automatic put_run(input logic lvl, input int unsigned n);
        repeat (n) put_level(lvl);
    endtask

    // Hold off the sender until every expected gesture has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.backlog() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_threshold(idx, val);
        @(posedge aclk);
    endtask

    // The block must be idle when this is called.
    task automatic program_thresholds(input logic [CFG_DATA_W-1:0] gap,
                                      input logic [CFG_DATA_W-1:0] click,
                                      input logic [CFG_DATA_W-1:0] hold);
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_DOUBLE_GAP, gap);
        write_reg(REG_SHORT_PRESS, click);
        write_reg(REG_LONG_PRESS, hold);
        cfg_we <= 1'b0;
    endtask

    // For thresholds up to 40, a run length that lands below, on or just past the threshold; else one below it.
    function automatic int unsigned near_limit(input logic [CFG_DATA_W-1:0] lim);
        int unsigned lo;
        if (lim > 40) return $urandom_range(1, 40);
        lo = (lim > 2) ? lim - 2 : 1;
        case ($urandom_range(0, 2))
            0: return $urandom_range(1, 3);
            1: return $urandom_range(lo, lim + 3);
            default: return $urandom_range(1, lim + 6);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold(input int unsigned small_max);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, small_max);
            default: return $urandom_range(250, 260);
        endcase
    endfunction

    // Press/release sequences with random lengths around the thresholds,
    // mixed with short glitch noise.
    task automatic run_gestures(input int unsigned n_samples);
        int unsigned stop_at;
        stop_at = samples_sent + n_samples;
        while (samples_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) put_level($urandom_range(0, 1));
            end else begin
                put_run(1'b0, near_limit($urandom_range(0, 1) ? sb.click_thr : sb.hold_thr));
                put_run(1'b1, near_limit(sb.gap_thr));
            end
            if ($urandom_range(0, 29) == 0) wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        thr_kind_t kind;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero thresholds, with the line already low at the first sample.
        program_thresholds('0, '0, '0);
        put_run(1'b0, 2);
        put_run(1'b1, 2);
        put_run(1'b0, 1);
        put_run(1'b1, 1);
        wait_for_results();

        // Single click, double click, then a long press.
        program_thresholds(3, 3, 4);
        put_run(1'b0, 2);
        put_run(1'b1, 5);
        put_run(1'b0, 1);
        put_run(1'b1, 1);
        put_run(1'b0, 1);
        put_run(1'b1, 2);
        put_run(1'b0, 6);
        put_run(1'b1, 1);
        wait_for_results();

        // Counters held at saturation; the compares must stay true.
        program_thresholds(254, '1, 254);
        put_run(1'b0, 270);
        put_run(1'b1, 270);
        put_run(1'b0, 3);
        put_run(1'b1, 260);
        wait_for_results();

        for (int ph = 0; ph < 10; ph++) begin
            kind = thr_kind_t'(ph % 4);
            gaps_on = ($urandom_range(0, 3) != 0);
            case (kind)
                THR_SMALL: program_thresholds($urandom_range(0, 12), $urandom_range(0, 15),
                                              $urandom_range(0, 20));
                THR_ZERO:  program_thresholds('0, '0, '0);
                THR_MAX:   program_thresholds('1, '1, '1);
                default:   program_thresholds(pick_threshold(12), pick_threshold(15),
                                              pick_threshold(20));
            endcase
            run_gestures(100);
            wait_for_results();
        end

        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.backlog() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
sv/bcc_pkg.sv
sv/button_click_classifier.sv
tb/tb.sv
